FILE: sv/cau_pkg.sv
package cau_pkg;

    // operation codes of a request
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // status codes of a result
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_DIVZ = 2'd1;
    localparam logic [1:0] STAT_OVF  = 2'd2;

    // request queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    // saturation bounds of a 32-bit result part
    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] a_real;
        logic signed [31:0] a_imag;
        logic signed [31:0] b_real;
        logic signed [31:0] b_imag;
    } t_req;

    typedef struct packed {
        logic signed [31:0] res_real;
        logic signed [31:0] res_imag;
        logic [1:0]         status;
    } t_res;

    typedef enum logic [2:0] {
        KIND_ADD,
        KIND_SUB,
        KIND_MUL,
        KIND_DIV,
        KIND_DIVZ
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] ar;
        logic signed [31:0] ai;
        logic signed [31:0] br;
        logic signed [31:0] bi;
    } t_item;

    typedef struct packed {
        logic busy;
        logic fin;
    } t_div_stat;

    typedef struct packed {
        logic signed [31:0] value;
        logic               ovf;
    } t_sat;

    // clamp a wide signed value to 32 bits
    function automatic t_sat sat66(input logic signed [65:0] v);
        t_sat r;
        if (v > SAT_MAX) begin
            r.value = 32'sh7FFFFFFF;
            r.ovf   = 1'b1;
        end else if (v < SAT_MIN) begin
            r.value = 32'sh80000000;
            r.ovf   = 1'b1;
        end else begin
            r.value = v[31:0];
            r.ovf   = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: sv/cau_front.sv
module cau_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  cau_pkg::t_req i_req,
    output logic          o_busy,
    input  logic          i_pop,
    output logic          o_valid,
    output cau_pkg::t_item o_item
);

    cau_pkg::t_item           r_mem [cau_pkg::QDEPTH];
    logic [cau_pkg::QAW-1:0]  r_wr;
    logic [cau_pkg::QAW-1:0]  r_rd;
    logic [cau_pkg::QCW-1:0]  r_cnt;
    logic                     push;
    logic                     pop;
    cau_pkg::t_item           cls;

    // classify the request
    always_comb begin
        cls.ar = i_req.a_real;
        cls.ai = i_req.a_imag;
        cls.br = i_req.b_real;
        cls.bi = i_req.b_imag;
        unique case (i_req.req_type)
            cau_pkg::OP_ADD: cls.kind = cau_pkg::KIND_ADD;
            cau_pkg::OP_SUB: cls.kind = cau_pkg::KIND_SUB;
            cau_pkg::OP_MUL: cls.kind = cau_pkg::KIND_MUL;
            cau_pkg::OP_DIV: cls.kind = (i_req.b_real == 32'sd0 && i_req.b_imag == 32'sd0)
                                        ? cau_pkg::KIND_DIVZ : cau_pkg::KIND_DIV;
        endcase
    end

    assign o_busy  = (r_cnt == cau_pkg::QCW'(cau_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_start && !o_busy;
    assign pop     = i_pop && o_valid;
    assign o_item  = r_mem[r_rd];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= cls;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: sv/cau_div.sv
module cau_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [63:0]        i_num_re,
    input  logic [63:0]        i_num_im,
    input  logic [63:0]        i_den,
    output cau_pkg::t_div_stat o_stat,
    output logic [31:0]        o_q_re,
    output logic [31:0]        o_q_im,
    output logic               o_ovf_re,
    output logic               o_ovf_im
);

    localparam int NW = 64 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_fin;
    logic [CW-1:0] r_cnt;
    logic [63:0]   r_den;
    logic [63:0]   r_rem_re;
    logic [63:0]   r_rem_im;
    logic [63:0]   r_sh_re;
    logic [63:0]   r_sh_im;
    logic [31:0]   r_q_re;
    logic [31:0]   r_q_im;
    logic          r_ovf_re;
    logic          r_ovf_im;
    logic [64:0]   rem2_re;
    logic [64:0]   rem2_im;
    logic          ge_re;
    logic          ge_im;
    logic [63:0]   n_rem_re;
    logic [63:0]   n_rem_im;

    // one restoring step on each part, sharing the divisor
    always_comb begin
        rem2_re  = {r_rem_re, r_sh_re[63]};
        rem2_im  = {r_rem_im, r_sh_im[63]};
        ge_re    = (rem2_re >= {1'b0, r_den});
        ge_im    = (rem2_im >= {1'b0, r_den});
        n_rem_re = ge_re ? 64'(rem2_re - {1'b0, r_den}) : rem2_re[63:0];
        n_rem_im = ge_im ? 64'(rem2_im - {1'b0, r_den}) : rem2_im[63:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // datapath, quotient bits beyond bit 31 only mark overflow
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den    <= i_den;
            r_rem_re <= '0;
            r_rem_im <= '0;
            r_sh_re  <= i_num_re;
            r_sh_im  <= i_num_im;
            r_q_re   <= '0;
            r_q_im   <= '0;
            r_ovf_re <= 1'b0;
            r_ovf_im <= 1'b0;
        end else if (r_busy) begin
            r_rem_re <= n_rem_re;
            r_rem_im <= n_rem_im;
            r_sh_re  <= {r_sh_re[62:0], 1'b0};
            r_sh_im  <= {r_sh_im[62:0], 1'b0};
            r_q_re   <= {r_q_re[30:0], ge_re};
            r_q_im   <= {r_q_im[30:0], ge_im};
            r_ovf_re <= r_ovf_re | r_q_re[31];
            r_ovf_im <= r_ovf_im | r_q_im[31];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.fin  = r_fin;
    assign o_q_re      = r_q_re;
    assign o_q_im      = r_q_im;
    assign o_ovf_re    = r_ovf_re;
    assign o_ovf_im    = r_ovf_im;

endmodule

FILE: sv/cau_back.sv
module cau_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cau_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_done,
    output cau_pkg::t_res  o_res
);

    localparam logic signed [65:0] BIAS = (66'sd1 <<< FRAC_BITS) - 66'sd1;

    // product stage
    logic                r_v1;
    cau_pkg::t_kind      r_kind;
    logic signed [63:0]  r_p_rr;
    logic signed [63:0]  r_p_ii;
    logic signed [63:0]  r_p_ri;
    logic signed [63:0]  r_p_ir;
    logic signed [63:0]  r_p_bb;
    logic signed [63:0]  r_p_cc;
    logic signed [32:0]  r_s_re;
    logic signed [32:0]  r_s_im;
    logic signed [63:0]  n_p_rr;
    logic signed [63:0]  n_p_ii;
    logic signed [63:0]  n_p_ri;
    logic signed [63:0]  n_p_ir;
    logic signed [63:0]  n_p_bb;
    logic signed [63:0]  n_p_cc;
    logic signed [32:0]  n_s_re;
    logic signed [32:0]  n_s_im;

    // divide sign and output register
    logic                r_dneg_re;
    logic                r_dneg_im;
    logic                r_done;
    cau_pkg::t_res       r_res;
    cau_pkg::t_res       n_res;

    logic                stall;
    logic                adv1;
    logic                div_start;
    logic signed [65:0]  m_re;
    logic signed [65:0]  m_im;
    logic signed [65:0]  mt_re;
    logic signed [65:0]  mt_im;
    logic signed [65:0]  num_re;
    logic signed [65:0]  num_im;
    logic [63:0]         mag_re;
    logic [63:0]         mag_im;
    logic [63:0]         den;
    logic signed [65:0]  dv_re;
    logic signed [65:0]  dv_im;
    cau_pkg::t_sat       sat_re;
    cau_pkg::t_sat       sat_im;
    cau_pkg::t_div_stat  div_stat;
    logic [31:0]         q_re;
    logic [31:0]         q_im;
    logic                qovf_re;
    logic                qovf_im;

    // stage control
    assign stall     = div_stat.busy || div_stat.fin;
    assign adv1      = r_v1 && !stall;
    assign o_pop     = i_valid && (!r_v1 || adv1);
    assign div_start = adv1 && (r_kind == cau_pkg::KIND_DIV);

    // products and sums for the product stage
    always_comb begin
        n_p_rr = i_item.ar * i_item.br;
        n_p_ii = i_item.ai * i_item.bi;
        n_p_ri = i_item.ar * i_item.bi;
        n_p_ir = i_item.ai * i_item.br;
        n_p_bb = i_item.br * i_item.br;
        n_p_cc = i_item.bi * i_item.bi;
        if (i_item.kind == cau_pkg::KIND_SUB) begin
            n_s_re = 33'(i_item.ar) - 33'(i_item.br);
            n_s_im = 33'(i_item.ai) - 33'(i_item.bi);
        end else begin
            n_s_re = 33'(i_item.ar) + 33'(i_item.br);
            n_s_im = 33'(i_item.ai) + 33'(i_item.bi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_pop) begin
            r_v1 <= 1'b1;
        end else if (adv1) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_item.kind;
            r_p_rr <= n_p_rr;
            r_p_ii <= n_p_ii;
            r_p_ri <= n_p_ri;
            r_p_ir <= n_p_ir;
            r_p_bb <= n_p_bb;
            r_p_cc <= n_p_cc;
            r_s_re <= n_s_re;
            r_s_im <= n_s_im;
        end
    end

    // multiply: exact sums, truncation toward zero
    always_comb begin
        m_re  = 66'(r_p_rr) - 66'(r_p_ii);
        m_im  = 66'(r_p_ri) + 66'(r_p_ir);
        mt_re = (m_re + (m_re[65] ? BIAS : 66'sd0)) >>> FRAC_BITS;
        mt_im = (m_im + (m_im[65] ? BIAS : 66'sd0)) >>> FRAC_BITS;
    end

    // divide operands: conjugate product over squared magnitude
    always_comb begin
        num_re = 66'(r_p_rr) + 66'(r_p_ii);
        num_im = 66'(r_p_ir) - 66'(r_p_ri);
        mag_re = num_re[65] ? 64'(-num_re) : num_re[63:0];
        mag_im = num_im[65] ? 64'(-num_im) : num_im[63:0];
        den    = 64'($unsigned(r_p_bb)) + 64'($unsigned(r_p_cc));
    end

    cau_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num_re (mag_re),
        .i_num_im (mag_im),
        .i_den    (den),
        .o_stat   (div_stat),
        .o_q_re   (q_re),
        .o_q_im   (q_im),
        .o_ovf_re (qovf_re),
        .o_ovf_im (qovf_im)
    );

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_dneg_re <= num_re[65];
            r_dneg_im <= num_im[65];
        end
    end

    // result selection and saturation
    always_comb begin
        dv_re  = r_dneg_re ? -66'($unsigned(q_re)) : 66'($unsigned(q_re));
        dv_im  = r_dneg_im ? -66'($unsigned(q_im)) : 66'($unsigned(q_im));
        sat_re = cau_pkg::sat66(66'(r_s_re));
        sat_im = cau_pkg::sat66(66'(r_s_im));
        n_res  = '0;
        priority if (div_stat.fin) begin
            sat_re = cau_pkg::sat66(dv_re);
            sat_im = cau_pkg::sat66(dv_im);
            if (qovf_re) begin
                sat_re.value = r_dneg_re ? 32'sh80000000 : 32'sh7FFFFFFF;
                sat_re.ovf   = 1'b1;
            end
            if (qovf_im) begin
                sat_im.value = r_dneg_im ? 32'sh80000000 : 32'sh7FFFFFFF;
                sat_im.ovf   = 1'b1;
            end
        end else if (r_kind == cau_pkg::KIND_MUL) begin
            sat_re = cau_pkg::sat66(mt_re);
            sat_im = cau_pkg::sat66(mt_im);
        end else begin
            sat_re = cau_pkg::sat66(66'(r_s_re));
            sat_im = cau_pkg::sat66(66'(r_s_im));
        end
        n_res.res_real = sat_re.value;
        n_res.res_imag = sat_im.value;
        n_res.status   = (sat_re.ovf || sat_im.ovf) ? cau_pkg::STAT_OVF : cau_pkg::STAT_OK;
        if (!div_stat.fin && r_kind == cau_pkg::KIND_DIVZ) begin
            n_res.res_real = '0;
            n_res.res_imag = '0;
            n_res.status   = cau_pkg::STAT_DIVZ;
        end
    end

    // output register, one strobe per result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= div_stat.fin || (adv1 && r_kind != cau_pkg::KIND_DIV);
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    // checks
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy && !div_stat.fin)
        else $error("divider started while in use");

    a_div_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.fin |=> r_done)
        else $error("divide result not delivered");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && stall) |=> r_v1 && $stable(r_kind))
        else $error("product stage moved during divide");

endmodule

FILE: sv/complex_arithmetic_unit.sv
// channel   | ports                 | handshake
// request   | start, i_req          | transfer when start high and busy low
// result    | o_done, o_res         | one-cycle strobe, always taken
//
// add, subtract, multiply: one request per clock while no divide holds the back end;
// the result strobe is registered through the queue, product stage and output register
// divide: the shared bit-serial divider holds the back end until its quotient is done;
// the four-entry queue keeps taking requests until it fills, then busy
// reset is synchronous and active low, clears the queue and all valid flags
module complex_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  cau_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output cau_pkg::t_res o_res
);

    logic           pop;
    logic           q_valid;
    cau_pkg::t_item q_item;

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_req),
        .o_busy  (busy),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    cau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (pop),
        .o_done  (o_done),
        .o_res   (o_res)
    );

endmodule
